### hw/rtl/ssi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sparse-set index block.
// ---------------------------------------------------------------------------
package ssi_pkg;

  localparam int CAPACITY = 256;
  localparam int MAX_IDS  = 1024;

  localparam int ID_W    = 10;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    moved_id;
    logic [COUNT_W-1:0] count_after;
    logic [STAT_W-1:0]  status;
  } rsp_t;

endpackage

### hw/rtl/sparse_set_index.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse_set_index
// Sparse-set index: add appends an id to a dense list, remove swaps the last
// dense entry into the freed slot. Two synchronous memories hold the tables.
// ---------------------------------------------------------------------------
// a new request is accepted only in S_IDLE, after the previous one has
//   left S_EXEC; both tables are read in the accept cycle and written back
//   when the result is registered, the following cycle unless the previous
//   response beat is still stalled
// reset clears the held count and the control state; table contents are
//   left as they are and have no clearing pass
module sparse_set_index (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ssi_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ssi_pkg::rsp_t rsp
);
  import ssi_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  localparam logic [ID_W:0]    ID_LIMIT  = (ID_W + 1)'(MAX_IDS);
  localparam logic [COUNT_W:0] CAP_LIMIT = (COUNT_W + 1)'(CAPACITY);

  state_t state, state_next;

  logic [SLOT_W-1:0] pos_mem [MAX_IDS];
  logic [ID_W-1:0]   id_mem  [CAPACITY];
  logic [SLOT_W-1:0] pos_rdata;
  logic [ID_W-1:0]   id_rdata;

  logic [COUNT_W-1:0] count, count_next;
  req_t               op;

  logic              pos_we;
  logic [ID_W-1:0]   pos_waddr;
  logic [SLOT_W-1:0] pos_wdata;
  logic              id_we;
  logic [SLOT_W-1:0] id_waddr;
  logic [ID_W-1:0]   id_wdata;

  logic       accept;
  logic       out_free;
  logic       done;
  rsp_t       result;
  logic       id_ok;
  logic       is_full;
  logic [SLOT_W-1:0] last_slot;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign done      = (state == S_EXEC) && out_free;
  assign last_slot = SLOT_W'(count - COUNT_W'(1));
  assign id_ok     = ({1'b0, op.id} < ID_LIMIT);
  assign is_full   = ({1'b0, count} >= CAP_LIMIT);

  // both tables are read on the request beat; data holds until the next beat
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_rdata <= pos_mem[req.id];
      id_rdata  <= id_mem[last_slot];
    end
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
  end

  always_comb begin
    result     = '0;
    count_next = count;
    pos_we     = 1'b0;
    pos_waddr  = op.id;
    pos_wdata  = SLOT_W'(count);
    id_we      = 1'b0;
    id_waddr   = SLOT_W'(count);
    id_wdata   = op.id;
    if (op.command == CMD_ADD) begin
      result.moved_id    = op.id;
      result.count_after = count;
      if (is_full) begin
        result.status = ST_FULL_EMPTY;
      end else if (!id_ok) begin
        result.status = ST_RANGE;
      end else begin
        result.status      = ST_OK;
        result.slot        = SLOT_W'(count);
        count_next         = count + COUNT_W'(1);
        result.count_after = count_next;
        pos_we             = done;
        id_we              = done;
      end
    end else begin
      if (count == '0) begin
        result.status = ST_FULL_EMPTY;
      end else if (!id_ok) begin
        result.status      = ST_RANGE;
        result.count_after = count;
      end else begin
        // last entry moves into the vacated slot
        result.status      = ST_OK;
        result.slot        = pos_rdata;
        result.moved_id    = id_rdata;
        count_next         = count - COUNT_W'(1);
        result.count_after = count_next;
        pos_waddr          = id_rdata;
        pos_wdata          = pos_rdata;
        id_waddr           = pos_rdata;
        id_wdata           = id_rdata;
        pos_we             = done;
        id_we              = done;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req;
    end
    if (done) begin
      rsp <= result;
    end
  end

endmodule

### hw/rtl/ssi_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssi_checker
// Port-level checks for the sparse-set index, bound to the top level.
// ---------------------------------------------------------------------------
module ssi_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ssi_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ssi_pkg::rsp_t rsp
);
  import ssi_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_no_rsp_after_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_FULL_EMPTY ||
                  rsp.status == ST_RANGE)
    else $error("undefined status code");

  // a request taken while no response beat is pending is answered without a stall
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
    else $error("response not produced in time");

endmodule

bind sparse_set_index ssi_checker u_ssi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
